/* hw/rtl/mrtp_pkg.sv */
`timescale 1ns / 1ps

package mrtp_pkg;

	localparam int ACC_W  = 64;
	localparam int BASE_W = 6;
	localparam int PROD_W = ACC_W + BASE_W;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_END     = 2'd2;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] LETTER_OFS = 8'd10;

	typedef struct packed {
		logic              is_sep;
		logic              is_sign;
		logic              is_minus;
		logic              is_digit;
		logic [BASE_W-1:0] digit;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t r;
		logic [7:0]  d;
		r = '0;
		d = '0;
		r.is_sep   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
		r.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
		r.is_minus = (c == CH_MINUS);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r.is_digit = 1'b1;
			d = c - CH_ZERO;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			r.is_digit = 1'b1;
			d = c - CH_UA + LETTER_OFS;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			r.is_digit = 1'b1;
			d = c - CH_LA + LETTER_OFS;
		end
		r.digit = d[BASE_W-1:0];
		return r;
	endfunction

endpackage

/* hw/rtl/mrtp_mac.sv */
`timescale 1ns / 1ps

module mrtp_mac (
	input  logic [mrtp_pkg::ACC_W-1:0]  acc,
	input  logic [mrtp_pkg::BASE_W-1:0] base,
	input  logic [mrtp_pkg::BASE_W-1:0] digit,
	output logic [mrtp_pkg::ACC_W-1:0]  acc_next,
	output logic                        overflow
);

	localparam logic [mrtp_pkg::PROD_W-1:0] LIMIT =
		mrtp_pkg::PROD_W'(1) << (mrtp_pkg::ACC_W - 1);

	logic [mrtp_pkg::PROD_W-1:0] prod;
	logic [mrtp_pkg::PROD_W-1:0] sum;

	// A step overflows when acc * base + digit passes 2^63, which matches the
	// usual "acc > (limit - digit) / base" test without a divider.
	assign prod     = mrtp_pkg::PROD_W'(acc) * mrtp_pkg::PROD_W'(base);
	assign sum      = prod + mrtp_pkg::PROD_W'(digit);
	assign overflow = (sum > LIMIT);
	assign acc_next = sum[mrtp_pkg::ACC_W-1:0];

endmodule

/* hw/rtl/min_radix_number_token_parser.sv */
`timescale 1ns / 1ps

// A character that does not close a token is taken while busy stays low.
// An invalid result for a rejected character appears in the cycle after it is accepted.
// A closing separator starts a conversion of its N stored digits, one multiply-accumulate
// per digit read from the digit memory, then registers the result; busy meanwhile.
// End of stream gives an end result of its own, after the result of any open token. Results cannot be stalled.
// Reset clears the token state at once; the digit memory is not cleared.
module min_radix_number_token_parser #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [7:0]         char_code,
	input  logic               end_of_stream,
	output logic               busy,
	output logic               result_strobe,
	output logic [1:0]         status,
	output logic [5:0]         min_base,
	output logic signed [63:0] value,
	output logic               last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_ENDR = 2'd2;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [5:0]    base_q;
	logic          nz_q;
	logic          sign_q;
	logic          neg_q;
	logic          in_tok_q;
	logic          swallow_q;
	logic          eos_pend_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] ndig_q;
	logic [63:0]   m_q;
	logic          over_q;

	logic [5:0]    mem [CAPACITY];
	logic [5:0]    rdata_q;

	logic               strobe_q;
	logic [1:0]         status_q;
	logic [5:0]         base_out_q;
	logic signed [63:0] value_q;
	logic               last_q;

	mrtp_pkg::char_class_t cls;
	logic          accept;
	logic          take_char;
	logic          nz_new;
	logic [5:0]    base_new;
	logic          store_dig;
	logic [CW-1:0] count_new;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic          cap_hit;
	logic          fail_now;
	logic [5:0]    fail_base;
	logic [63:0]   acc_next;
	logic          mac_over;
	logic          fin_invalid;
	logic [63:0]   fin_value;

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && !busy;
	assign take_char     = accept && !end_of_stream && !swallow_q;
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign min_base      = base_out_q;
	assign value         = value_q;
	assign last          = last_q;

	always_comb begin
		cls       = mrtp_pkg::classify(char_code);
		nz_new    = nz_q || (cls.digit != '0);
		base_new  = (cls.digit >= base_q) ? (cls.digit + 6'd1) : base_q;
		// Leading zeros are dropped until a nonzero digit has been seen.
		store_dig = cls.is_digit && nz_new;
		count_new = count_q + CW'(store_dig);
		wr_addr   = AW'(count_q - CW'(sign_q));
		mem_we    = take_char && store_dig;
		cap_hit   = cls.is_digit && (count_new >= CW'(CAPACITY));
		fail_now  = take_char && !cls.is_sep &&
			((cls.is_sign && count_q != '0) || cap_hit ||
			 (!cls.is_sign && !cls.is_digit));
		fail_base = cls.is_digit ? base_new : base_q;
		// Prefetch the next digit so that one digit is consumed every cycle.
		rd_addr   = (state_q == S_CONV) ? AW'(idx_q + CW'(1)) : '0;
	end

	always_comb begin
		fin_value   = neg_q ? (~m_q + 64'd1) : m_q;
		fin_invalid = over_q || (neg_q ? m_q[63] : (m_q >= POS_LIMIT));
	end

	mrtp_mac u_mac (
		.acc      (m_q),
		.base     (base_q),
		.digit    (rdata_q),
		.acc_next (acc_next),
		.overflow (mac_over)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cls.digit;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			base_q     <= mrtp_pkg::BASE_MIN;
			nz_q       <= 1'b0;
			sign_q     <= 1'b0;
			neg_q      <= 1'b0;
			in_tok_q   <= 1'b0;
			swallow_q  <= 1'b0;
			eos_pend_q <= 1'b0;
			idx_q      <= '0;
			ndig_q     <= '0;
			m_q        <= '0;
			over_q     <= 1'b0;
			strobe_q   <= 1'b0;
			status_q   <= mrtp_pkg::ST_OK;
			base_out_q <= mrtp_pkg::BASE_MIN;
			value_q    <= '0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && end_of_stream) begin
						swallow_q <= 1'b0;
						if (in_tok_q) begin
							state_q    <= S_CONV;
							eos_pend_q <= 1'b1;
							idx_q      <= '0;
							ndig_q     <= count_q - CW'(sign_q);
							m_q        <= '0;
							over_q     <= 1'b0;
						end else begin
							strobe_q   <= 1'b1;
							status_q   <= mrtp_pkg::ST_END;
							base_out_q <= mrtp_pkg::BASE_MIN;
							value_q    <= '0;
							last_q     <= 1'b1;
						end
					end else if (accept && swallow_q) begin
						swallow_q <= 1'b0;
					end else if (fail_now) begin
						strobe_q   <= 1'b1;
						status_q   <= mrtp_pkg::ST_INVALID;
						base_out_q <= fail_base;
						value_q    <= '0;
						last_q     <= 1'b1;
						swallow_q  <= cap_hit;
						count_q    <= '0;
						base_q     <= mrtp_pkg::BASE_MIN;
						nz_q       <= 1'b0;
						sign_q     <= 1'b0;
						neg_q      <= 1'b0;
						in_tok_q   <= 1'b0;
					end else if (take_char && cls.is_sep) begin
						if (in_tok_q) begin
							state_q    <= S_CONV;
							eos_pend_q <= 1'b0;
							idx_q      <= '0;
							ndig_q     <= count_q - CW'(sign_q);
							m_q        <= '0;
							over_q     <= 1'b0;
						end
					end else if (take_char && cls.is_sign) begin
						in_tok_q <= 1'b1;
						sign_q   <= 1'b1;
						neg_q    <= cls.is_minus;
						count_q  <= CW'(1);
					end else if (take_char && cls.is_digit) begin
						in_tok_q <= 1'b1;
						nz_q     <= nz_new;
						base_q   <= base_new;
						count_q  <= count_new;
					end
				end
				S_CONV: begin
					if (idx_q == ndig_q) begin
						strobe_q   <= 1'b1;
						status_q   <= fin_invalid ? mrtp_pkg::ST_INVALID : mrtp_pkg::ST_OK;
						base_out_q <= base_q;
						value_q    <= fin_invalid ? '0 : fin_value;
						last_q     <= !eos_pend_q;
						count_q    <= '0;
						base_q     <= mrtp_pkg::BASE_MIN;
						nz_q       <= 1'b0;
						sign_q     <= 1'b0;
						neg_q      <= 1'b0;
						in_tok_q   <= 1'b0;
						state_q    <= eos_pend_q ? S_ENDR : S_IDLE;
					end else begin
						if (!over_q) begin
							if (mac_over) begin
								over_q <= 1'b1;
							end else begin
								m_q <= acc_next;
							end
						end
						idx_q <= idx_q + CW'(1);
					end
				end
				S_ENDR: begin
					strobe_q   <= 1'b1;
					status_q   <= mrtp_pkg::ST_END;
					base_out_q <= mrtp_pkg::BASE_MIN;
					value_q    <= '0;
					last_q     <= 1'b1;
					eos_pend_q <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CAPACITY    = 64;
	localparam int ITEM_TARGET = 1450;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  base;
		logic [63:0] value;
		logic        last;
	} token_result_t;

	// Tracks the token being parsed and queues the results it must produce.
	class radix_scoreboard;
		logic [5:0]    digit_val [CAPACITY];
		int unsigned   stored;
		logic [5:0]    base;
		bit            nonzero;
		bit            has_sign;
		bit            neg;
		bit            open;
		bit            skip_next;
		token_result_t pending_results[$];
		int unsigned   errors;

		function new();
			clear_token();
			skip_next = 0;
			errors = 0;
		endfunction

		function void clear_token();
			stored = 0;
			base = mrtp_pkg::BASE_MIN;
			nonzero = 0;
			has_sign = 0;
			neg = 0;
			open = 0;
		endfunction

		function void push(logic [1:0] st, logic [5:0] b, logic [63:0] v, logic lst);
			token_result_t r;
			r.status = st;
			r.base = b;
			r.value = v;
			r.last = lst;
			pending_results.push_back(r);
		endfunction

		function void reject();
			push(mrtp_pkg::ST_INVALID, base, 64'd0, 1'b1);
			clear_token();
		endfunction

		// Accumulates the stored digits in the tracked radix and closes the token.
		function void convert_token(logic lst);
			logic [63:0] lim;
			logic [63:0] acc;
			logic [63:0] dv;
			logic [63:0] bv;
			int unsigned ndig;
			bit          over;
			lim = 64'h8000_0000_0000_0000;
			ndig = stored - (has_sign ? 1 : 0);
			bv = 64'(base);
			acc = '0;
			over = 0;
			for (int i = 0; i < ndig; i++) begin
				dv = 64'(digit_val[i]);
				if (!over) begin
					if (acc > (lim - dv) / bv)
						over = 1;
					else
						acc = acc * bv + dv;
				end
			end
			if (over || (neg ? (acc > lim - 64'd1) : (acc >= lim - 64'd1)))
				push(mrtp_pkg::ST_INVALID, base, 64'd0, lst);
			else
				push(mrtp_pkg::ST_OK, base, neg ? -acc : acc, lst);
			clear_token();
		endfunction

		function void note_input(logic [7:0] c, logic eos);
			logic [5:0] dv;
			if (eos) begin
				skip_next = 0;
				if (open)
					convert_token(1'b0);
				push(mrtp_pkg::ST_END, mrtp_pkg::BASE_MIN, 64'd0, 1'b1);
				return;
			end
			if (skip_next) begin
				skip_next = 0;
				return;
			end
			if (c == mrtp_pkg::CH_SPACE || c == mrtp_pkg::CH_TAB || c == mrtp_pkg::CH_LF) begin
				if (open)
					convert_token(1'b1);
				return;
			end
			open = 1;
			if (c == mrtp_pkg::CH_PLUS || c == mrtp_pkg::CH_MINUS) begin
				if (stored != 0) begin
					reject();
					return;
				end
				has_sign = 1;
				neg = (c == mrtp_pkg::CH_MINUS);
				stored = 1;
			end else begin
				if (c >= mrtp_pkg::CH_ZERO && c <= mrtp_pkg::CH_NINE)
					dv = 6'(c - mrtp_pkg::CH_ZERO);
				else if (c >= mrtp_pkg::CH_UA && c <= mrtp_pkg::CH_UZ)
					dv = 6'(c - mrtp_pkg::CH_UA + mrtp_pkg::LETTER_OFS);
				else if (c >= mrtp_pkg::CH_LA && c <= mrtp_pkg::CH_LZ)
					dv = 6'(c - mrtp_pkg::CH_LA + mrtp_pkg::LETTER_OFS);
				else begin
					reject();
					return;
				end
				if (dv != 0)
					nonzero = 1;
				if (dv >= base)
					base = dv + 6'd1;
				// Leading zeros neither widen the radix nor are stored.
				if (nonzero) begin
					digit_val[stored - (has_sign ? 1 : 0)] = dv;
					stored++;
				end
			end
			if (stored >= CAPACITY) begin
				reject();
				skip_next = 1;
			end
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic [5:0] b, logic [63:0] v, logic lst);
			token_result_t w;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result status=%0d base=%0d value=%0d last=%0d",
					st, b, $signed(v), lst));
				return;
			end
			w = pending_results.pop_front();
			if (st !== w.status)
				report($sformatf("status %0d, wanted %0d", st, w.status));
			if (b !== w.base)
				report($sformatf("min_base %0d, wanted %0d", b, w.base));
			if (v !== w.value)
				report($sformatf("value %0d, wanted %0d", $signed(v), $signed(w.value)));
			if (lst !== w.last)
				report($sformatf("last %0d, wanted %0d", lst, w.last));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [7:0]         char_code = 8'd0;
	logic               end_of_stream = 1'b0;
	logic               busy;
	logic               result_strobe;
	logic [1:0]         status;
	logic [5:0]         min_base;
	logic signed [63:0] value;
	logic               last;

	radix_scoreboard sb = new();
	int unsigned     items_sent = 0;
	int unsigned     cycles = 0;

	min_radix_number_token_parser #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.char_code(char_code),
		.end_of_stream(end_of_stream),
		.busy(busy),
		.result_strobe(result_strobe),
		.status(status),
		.min_base(min_base),
		.value(value),
		.last(last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			sb.check_result(status, min_base, value, last);
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send(input logic [7:0] c, input logic eos);
		int unsigned idle;
		idle = (items_sent < 480) ? 12 : (items_sent < 960) ? 77 : 0;
		while ($urandom_range(0, 99) < idle) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		char_code <= c;
		end_of_stream <= eos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_input(c, eos);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	function automatic logic [7:0] digit_char(int unsigned d);
		if (d < 10)
			return mrtp_pkg::CH_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? mrtp_pkg::CH_UA : mrtp_pkg::CH_LA) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] sep_char();
		case ($urandom_range(0, 2))
			0: return mrtp_pkg::CH_SPACE;
			1: return mrtp_pkg::CH_TAB;
			default: return mrtp_pkg::CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] bad_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == mrtp_pkg::CH_SPACE || c == mrtp_pkg::CH_TAB || c == mrtp_pkg::CH_LF
			|| c == mrtp_pkg::CH_PLUS || c == mrtp_pkg::CH_MINUS
			|| (c >= mrtp_pkg::CH_ZERO && c <= mrtp_pkg::CH_NINE)
			|| (c >= mrtp_pkg::CH_UA && c <= mrtp_pkg::CH_UZ)
			|| (c >= mrtp_pkg::CH_LA && c <= mrtp_pkg::CH_LZ));
		return c;
	endfunction

	task automatic send_sign();
		send($urandom_range(0, 1) ? mrtp_pkg::CH_PLUS : mrtp_pkg::CH_MINUS, 1'b0);
	endtask

	task automatic send_digits(int unsigned n, int unsigned radix);
		repeat (n)
			send(digit_char($urandom_range(0, radix - 1)), 1'b0);
	endtask

	task automatic close_token();
		if ($urandom_range(0, 24) == 0)
			send(8'($urandom_range(0, 255)), 1'b1);
		else
			repeat ($urandom_range(1, 2))
				send(sep_char(), 1'b0);
	endtask

	task automatic send_token();
		int unsigned kind;
		int unsigned radix;
		string       lim;
		logic [7:0]  c;
		kind = $urandom_range(0, 99);
		radix = $urandom_range(2, 36);
		if (kind < 62) begin
			if ($urandom_range(0, 2) != 0)
				send_sign();
			repeat ($urandom_range(0, 3))
				send(mrtp_pkg::CH_ZERO, 1'b0);
			send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
				: $urandom_range(0, 8), radix);
			close_token();
		end else if (kind < 74) begin
			// Values at and around the signed 64-bit limits.
			if ($urandom_range(0, 1))
				send_sign();
			case ($urandom_range(0, 4))
				0: lim = "7FFFFFFFFFFFFFFF";
				1: lim = "8000000000000000";
				2: lim = "7FFFFFFFFFFFFFFE";
				3: lim = "1Y2P0IJ32E8E7";
				default: lim = "";
			endcase
			if (lim.len() == 0)
				repeat ($urandom_range(61, 63))
					send("1", 1'b0);
			else
				for (int i = 0; i < lim.len(); i++) begin
					c = lim[i];
					if (c >= mrtp_pkg::CH_UA && $urandom_range(0, 1))
						c = c + 8'd32;
					send(c, 1'b0);
				end
			close_token();
		end else if (kind < 84) begin
			send_digits($urandom_range(0, 3), 36);
			send(bad_char(), 1'b0);
			if ($urandom_range(0, 1))
				send_digits($urandom_range(1, 3), radix);
			close_token();
		end else if (kind < 89) begin
			if ($urandom_range(0, 1))
				send_sign();
			send(digit_char($urandom_range(1, radix - 1)), 1'b0);
			send_digits($urandom_range(0, 2), radix);
			send_sign();
			if ($urandom_range(0, 1))
				send_digits($urandom_range(1, 3), radix);
			close_token();
		end else if (kind < 93) begin
			// Fill the token to capacity; the byte after it is dropped.
			repeat ($urandom_range(0, 2))
				send(mrtp_pkg::CH_ZERO, 1'b0);
			if ($urandom_range(0, 1)) begin
				send_sign();
				send(digit_char($urandom_range(1, radix - 1)), 1'b0);
				send_digits(CAPACITY - 2, radix);
			end else begin
				send(digit_char($urandom_range(1, radix - 1)), 1'b0);
				send_digits(CAPACITY - 1, radix);
			end
			case ($urandom_range(0, 3))
				0: send(sep_char(), 1'b0);
				1: send(bad_char(), 1'b0);
				2: send(8'($urandom_range(0, 255)), 1'b1);
				default: send_digits(1, radix);
			endcase
			close_token();
		end else begin
			repeat ($urandom_range(1, 6))
				send(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("+00  - 0 zZ9\t1+\n7");
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		send_text("-7");
		send(8'h41, 1'b1);
		send(8'h00, 1'b1);

		while (items_sent < ITEM_TARGET)
			send_token();
		start <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8)
			@(posedge clk);

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
